[hw/rtl/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and constants for the Intel HEX record parser: commands,
// status codes, record types, special characters and inter-module structs.
// ----------------------------------------------------------------------------
package ihex_pkg;

  // Line buffer geometry
  localparam int BUF_DEPTH = 256;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);

  // Request commands
  typedef enum logic [1:0] {
    CMD_FEED    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EOF      = 3'd1,
    ST_BAD_CHAR = 3'd2,
    ST_NO_EOF   = 3'd3,
    ST_LENGTH   = 3'd4,
    ST_CHECKSUM = 3'd5,
    ST_BAD_ADDR = 3'd6,
    ST_READ     = 3'd7
  } status_t;

  // Line parser phase
  typedef enum logic [1:0] {
    PH_LINE    = 2'd0,
    PH_COMMENT = 2'd1,
    PH_RECORD  = 2'd2
  } phase_t;

  // Special characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Record types
  localparam logic [7:0] RT_EOF       = 8'd1;
  localparam logic [7:0] RT_EXT_SEG   = 8'd2;
  localparam logic [7:0] RT_START_SEG = 8'd3;
  localparam logic [7:0] RT_EXT_LIN   = 8'd4;
  localparam logic [7:0] RT_START_LIN = 8'd5;

  // Required payload lengths of address records
  localparam logic [7:0] LEN_ADDR16 = 8'd2;
  localparam logic [7:0] LEN_ADDR32 = 8'd4;

  // Digit counting: length, offset and type bytes plus checksum = 10 digits
  localparam logic [9:0] HDR_DIGITS = 10'd10;
  localparam logic [9:0] DC_MAX     = 10'h3FF;

  // Byte positions inside a record
  localparam logic [8:0] POS_LEN    = 9'd0;
  localparam logic [8:0] POS_OFS_HI = 9'd1;
  localparam logic [8:0] POS_OFS_LO = 9'd2;
  localparam logic [8:0] POS_TYPE   = 9'd3;
  localparam logic [8:0] POS_DATA   = 9'd4;
  localparam logic [8:0] PW_BYTES   = 9'd4;

  // Line buffer write port
  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } ihex_wr_t;

  // Report from the parser for one request
  typedef struct packed {
    logic    valid;
    status_t status;
  } ihex_rpt_t;

  // Record fields and kept address values shown with every result
  typedef struct packed {
    logic [7:0]  record_type;
    logic [7:0]  data_length;
    logic [15:0] load_offset;
    logic [15:0] segment_base;
    logic [31:0] segment_start;
    logic [15:0] linear_base;
    logic [31:0] linear_start;
  } ihex_view_t;

endpackage

[hw/rtl/ihex_parse.sv]
// ----------------------------------------------------------------------------
// ihex_parse
// Character-level record decoder. Holds the parse state, decodes one accepted
// request per cycle, produces the report, the updated field view and the line
// buffer write for data payload bytes.
// ----------------------------------------------------------------------------
module ihex_parse
  import ihex_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  cmd_t       cmd,
  input  logic [7:0] char_in,
  input  logic       image_end,
  output ihex_rpt_t  rpt,
  output ihex_view_t view,
  output ihex_wr_t   wr
);

  phase_t      phase_r,        phase_nxt;
  logic        finished_r,     finished_nxt;
  logic [9:0]  digit_count_r,  digit_count_nxt;
  logic [3:0]  high_nibble_r,  high_nibble_nxt;
  logic [7:0]  byte_sum_r,     byte_sum_nxt;
  logic [7:0]  field_length_r, field_length_nxt;
  logic [7:0]  field_type_r,   field_type_nxt;
  logic [15:0] field_offset_r, field_offset_nxt;
  logic [31:0] payload_r,      payload_nxt;
  logic [15:0] k_offset_r,     k_offset_nxt;
  logic [15:0] k_seg_base_r,   k_seg_base_nxt;
  logic [31:0] k_seg_start_r,  k_seg_start_nxt;
  logic [15:0] k_lin_base_r,   k_lin_base_nxt;
  logic [31:0] k_lin_start_r,  k_lin_start_nxt;

  logic [4:0]  hex;        // {valid, nibble}
  logic [7:0]  cur_byte;
  logic [8:0]  pos;
  logic [8:0]  pay_idx;
  logic [9:0]  dc_less;
  logic        len_bad;
  logic        is_data;
  logic        st_valid;
  status_t     st;

  // Hex digit decode, both cases
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end
    return r;
  endfunction

  assign hex      = hex_decode(char_in);
  assign cur_byte = {high_nibble_r, hex[3:0]};
  assign pos      = digit_count_r[9:1];
  assign pay_idx  = pos - POS_DATA;
  assign dc_less  = digit_count_r - HDR_DIGITS;
  assign len_bad  = (digit_count_r < HDR_DIGITS) || digit_count_r[0] ||
                    (dc_less[9:1] != {1'b0, field_length_r});
  assign is_data  = (field_type_r < RT_EOF) || (field_type_r > RT_START_LIN);

  // Next state and report
  always_comb begin
    phase_nxt        = phase_r;
    finished_nxt     = finished_r;
    digit_count_nxt  = digit_count_r;
    high_nibble_nxt  = high_nibble_r;
    byte_sum_nxt     = byte_sum_r;
    field_length_nxt = field_length_r;
    field_type_nxt   = field_type_r;
    field_offset_nxt = field_offset_r;
    payload_nxt      = payload_r;
    k_offset_nxt     = k_offset_r;
    k_seg_base_nxt   = k_seg_base_r;
    k_seg_start_nxt  = k_seg_start_r;
    k_lin_base_nxt   = k_lin_base_r;
    k_lin_start_nxt  = k_lin_start_r;
    st_valid         = 1'b0;
    st               = ST_OK;
    wr.en            = 1'b0;
    wr.addr          = pay_idx[BUF_AW-1:0];
    wr.data          = cur_byte;

    if (acc) begin
      case (cmd)
        CMD_READ: begin
          st_valid = 1'b1;
          st       = ST_READ;
        end
        CMD_RESTART: begin
          phase_nxt        = PH_LINE;
          finished_nxt     = 1'b0;
          digit_count_nxt  = '0;
          high_nibble_nxt  = '0;
          byte_sum_nxt     = '0;
          field_length_nxt = '0;
          field_type_nxt   = '0;
          field_offset_nxt = '0;
          payload_nxt      = '0;
          k_offset_nxt     = '0;
          k_seg_base_nxt   = '0;
          k_seg_start_nxt  = '0;
          k_lin_base_nxt   = '0;
          k_lin_start_nxt  = '0;
        end
        CMD_FEED: begin
          if (!finished_r) begin
            case (phase_r)
              PH_LINE: begin
                if (char_in == CH_HASH) begin
                  phase_nxt = PH_COMMENT;
                end else if (char_in == CH_COLON) begin
                  phase_nxt        = PH_RECORD;
                  digit_count_nxt  = '0;
                  high_nibble_nxt  = '0;
                  byte_sum_nxt     = '0;
                  field_length_nxt = '0;
                  field_type_nxt   = '0;
                  field_offset_nxt = '0;
                  payload_nxt      = '0;
                end else begin
                  st_valid = 1'b1;
                  st       = ST_BAD_CHAR;
                end
              end
              PH_COMMENT: begin
                if (char_in == CH_NL) phase_nxt = PH_LINE;
              end
              PH_RECORD: begin
                if (char_in == CH_NL) begin
                  // End of record: length, checksum, then type handling
                  phase_nxt = PH_LINE;
                  st_valid  = 1'b1;
                  if (len_bad) begin
                    st = ST_LENGTH;
                  end else if (byte_sum_r != 8'd0) begin
                    st = ST_CHECKSUM;
                  end else if (field_type_r == RT_EOF) begin
                    st = ST_EOF;
                  end else if (field_type_r == RT_EXT_SEG) begin
                    if (field_length_r != LEN_ADDR16) st = ST_BAD_ADDR;
                    else k_seg_base_nxt = payload_r[15:0];
                  end else if (field_type_r == RT_START_SEG) begin
                    if (field_length_r != LEN_ADDR32) st = ST_BAD_ADDR;
                    else k_seg_start_nxt = payload_r;
                  end else if (field_type_r == RT_EXT_LIN) begin
                    if (field_length_r != LEN_ADDR16) st = ST_BAD_ADDR;
                    else k_lin_base_nxt = payload_r[15:0];
                  end else if (field_type_r == RT_START_LIN) begin
                    if (field_length_r != LEN_ADDR32) st = ST_BAD_ADDR;
                    else k_lin_start_nxt = payload_r;
                  end else begin
                    k_offset_nxt = field_offset_r;
                  end
                end else if (!hex[4]) begin
                  st_valid = 1'b1;
                  st       = ST_BAD_CHAR;
                end else begin
                  // Digit: first nibble is held, second completes a byte
                  if (!digit_count_r[0]) begin
                    high_nibble_nxt = hex[3:0];
                  end else begin
                    byte_sum_nxt = byte_sum_r + cur_byte;
                    if (pos == POS_LEN) begin
                      field_length_nxt = cur_byte;
                    end else if (pos == POS_OFS_HI) begin
                      field_offset_nxt = {cur_byte, field_offset_r[7:0]};
                    end else if (pos == POS_OFS_LO) begin
                      field_offset_nxt = {field_offset_r[15:8], cur_byte};
                    end else if (pos == POS_TYPE) begin
                      field_type_nxt = cur_byte;
                    end else begin
                      if (pay_idx < PW_BYTES) payload_nxt = {payload_r[23:0], cur_byte};
                      if ((pay_idx < {1'b0, field_length_r}) && is_data) wr.en = 1'b1;
                    end
                  end
                  if (digit_count_r != DC_MAX) digit_count_nxt = digit_count_r + 10'd1;
                end
              end
              default: phase_nxt = PH_LINE;
            endcase

            // Any error or EOF ends parsing
            if (st_valid && st != ST_OK) finished_nxt = 1'b1;
            // Image ended without EOF record
            if (image_end && !finished_nxt) begin
              st_valid     = 1'b1;
              st           = ST_NO_EOF;
              finished_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Report and view of the state after this request
  always_comb begin
    rpt.valid          = st_valid;
    rpt.status         = st;
    view.record_type   = field_type_nxt;
    view.data_length   = field_length_nxt;
    view.load_offset   = k_offset_nxt;
    view.segment_base  = k_seg_base_nxt;
    view.segment_start = k_seg_start_nxt;
    view.linear_base   = k_lin_base_nxt;
    view.linear_start  = k_lin_start_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_LINE;
      finished_r     <= 1'b0;
      digit_count_r  <= '0;
      high_nibble_r  <= '0;
      byte_sum_r     <= '0;
      field_length_r <= '0;
      field_type_r   <= '0;
      field_offset_r <= '0;
      payload_r      <= '0;
      k_offset_r     <= '0;
      k_seg_base_r   <= '0;
      k_seg_start_r  <= '0;
      k_lin_base_r   <= '0;
      k_lin_start_r  <= '0;
    end else begin
      phase_r        <= phase_nxt;
      finished_r     <= finished_nxt;
      digit_count_r  <= digit_count_nxt;
      high_nibble_r  <= high_nibble_nxt;
      byte_sum_r     <= byte_sum_nxt;
      field_length_r <= field_length_nxt;
      field_type_r   <= field_type_nxt;
      field_offset_r <= field_offset_nxt;
      payload_r      <= payload_nxt;
      k_offset_r     <= k_offset_nxt;
      k_seg_base_r   <= k_seg_base_nxt;
      k_seg_start_r  <= k_seg_start_nxt;
      k_lin_base_r   <= k_lin_base_nxt;
      k_lin_start_r  <= k_lin_start_nxt;
    end
  end

endmodule

[hw/rtl/intel_hex_record_parser.sv]
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// Intel HEX text decoder with a 256-byte line buffer for data payload.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one request per cycle while in_stall is low. cmd
//   FEED passes one text character, READ returns line buffer entry
//   in_byte_index, RESTART clears the parser (buffer contents are kept).
//   Output channel (out_*): one result for each READ, for each completed
//   record, for the first error and for a missing EOF at image end.
//   Path: a result is registered in the parse/buffer read stage (stage A)
//   on its accept edge, then moves on to the output register (stage B).
//   Throughput: one request per cycle while in_stall is low; the character
//   decode is combinational and the line buffer read is registered.
//   Stall: two results can wait; in_stall rises only while both stages are
//   full and out_stall is high.
//   Reset: clears the parser and both result stages. The line buffer is not
//   cleared; an entry reads undefined until a data record writes it.
// ----------------------------------------------------------------------------
module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_char_in,
  input  logic        in_image_end,
  input  logic [7:0]  in_byte_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_record_type,
  output logic [7:0]  out_data_length,
  output logic [15:0] out_load_offset,
  output logic [15:0] out_segment_base,
  output logic [31:0] out_segment_start,
  output logic [15:0] out_linear_base,
  output logic [31:0] out_linear_start,
  output logic [7:0]  out_read_byte
);

  logic       in_acc;
  cmd_t       cmd;
  ihex_rpt_t  rpt;
  ihex_view_t view;
  ihex_wr_t   wr;

  // Line buffer
  logic [7:0] buf_mem [BUF_DEPTH];
  logic [7:0] rd_data_r;

  // Stage A: result with pending buffer data
  logic       a_valid_r;
  status_t    a_status_r;
  ihex_view_t a_view_r;
  logic       a_move;

  // Stage B: output register
  logic       b_valid_r;
  status_t    b_status_r;
  ihex_view_t b_view_r;
  logic [7:0] b_byte_r;

  assign cmd      = cmd_t'(in_cmd);
  assign a_move   = a_valid_r && (!b_valid_r || !out_stall);
  assign in_stall = a_valid_r && b_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  ihex_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .cmd       (cmd),
    .char_in   (in_char_in),
    .image_end (in_image_end),
    .rpt       (rpt),
    .view      (view),
    .wr        (wr)
  );

  // Buffer write of payload bytes, registered read for READ requests
  always_ff @(posedge clk) begin
    if (wr.en) buf_mem[wr.addr] <= wr.data;
    if (in_acc && cmd == CMD_READ) rd_data_r <= buf_mem[in_byte_index];
  end

  // Stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= rpt.valid;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_status_r <= rpt.status;
      a_view_r   <= view;
    end
  end

  // Stage B
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_move) begin
      b_valid_r <= 1'b1;
    end else if (!out_stall) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_status_r <= a_status_r;
      b_view_r   <= a_view_r;
      b_byte_r   <= (a_status_r == ST_READ) ? rd_data_r : 8'd0;
    end
  end

  // Output ports
  assign out_valid         = b_valid_r;
  assign out_status        = b_status_r;
  assign out_record_type   = b_view_r.record_type;
  assign out_data_length   = b_view_r.data_length;
  assign out_load_offset   = b_view_r.load_offset;
  assign out_segment_base  = b_view_r.segment_base;
  assign out_segment_start = b_view_r.segment_start;
  assign out_linear_base   = b_view_r.linear_base;
  assign out_linear_start  = b_view_r.linear_start;
  assign out_read_byte     = b_byte_r;

endmodule

[hw/rtl/ihex_chk.sv]
// ----------------------------------------------------------------------------
// ihex_chk
// Port-level checks for the Intel HEX record parser, bound to the top level.
// ----------------------------------------------------------------------------
module ihex_chk
  import ihex_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [7:0]  out_record_type,
  input logic [7:0]  out_read_byte
);

  // Reset empties the result stages
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // Only read results carry a buffer byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_READ) |-> out_read_byte == 8'd0)
    else $error("nonzero read byte on non-read result");

  // An EOF report comes only from a type 1 record
  a_eof_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EOF) |-> out_record_type == RT_EOF)
    else $error("EOF status with wrong record type");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
                                  $stable(out_read_byte)))
    else $error("stalled result changed");

endmodule

bind intel_hex_record_parser ihex_chk u_ihex_chk (.*);
